### design/imu_ca_pkg.sv
// imu_ca_pkg: shared types, constants and the CORDIC arctangent table for the
// complementary-filter attitude block. No dependencies.
package imu_ca_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    // widths
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 22;
    localparam int ANG_W      = 24;   // 1/32768 degree angle state
    localparam int XY_IN_W    = 25;   // CORDIC operand width
    localparam int SQ_IN_W    = 48;
    localparam int SQ_OUT_W   = 24;
    localparam int DIV_N_W    = 44;
    localparam int DIV_D_W    = 22;
    localparam int DIV_Q_W    = 24;
    localparam int PROD_W     = 59;

    // reciprocals for the constant divisors, floor(2^40 / d)
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = 21;
    localparam logic [RECIP_W-1:0] RECIP_US   = 21'd1099511;   // d = 10^6
    localparam logic [RECIP_W-1:0] RECIP_NORM = 21'd372827;    // d = 90 deg in 2^-15

    // fixed-point constants
    localparam int DEG90_Q16   = 5898240;
    localparam int ANGLE_LIMIT = 5898240;
    localparam int DEG45_Q15   = 1474560;
    localparam int DEG90_Q15   = 2949120;
    localparam int US_PER_S    = 1000000;
    localparam int US_ROUND    = 500000;
    localparam int GAIN_ONE    = 65536;

    // configuration
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z       = 3'd4;
    localparam logic [15:0] BLEND_GAIN_RST   = 16'd64225;
    localparam logic [15:0] GRAVITY_GAIN_RST = 16'd62259;

    // angle channel selector
    localparam logic [1:0] SEL_PITCH = 2'd0;
    localparam logic [1:0] SEL_ROLL  = 2'd1;
    localparam logic [1:0] SEL_YAW   = 2'd2;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [15:0]        elapsed_us;
    } t_imu_in;

    typedef struct packed {
        logic signed [15:0] pitch_out;
        logic signed [15:0] roll_out;
        logic signed [31:0] yaw_out;
        logic [15:0]        norm_pitch;
        logic [15:0]        norm_roll;
    } t_imu_out;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GRAV0, ST_GRAV1, ST_GRAV2,
        ST_SQ0, ST_SQ1, ST_SQ2, ST_SQW,
        ST_ATAN, ST_ATANW,
        ST_STEP0, ST_STEP1, ST_STEPW,
        ST_BLEND0, ST_BLEND1, ST_BLEND2,
        ST_YAW, ST_NORM, ST_NORMW, ST_DONE
    } t_state;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

### design/imu_ca_cordic.sv
// imu_ca_cordic: iterative vectoring CORDIC, atan2(y, x) in 1/32768 degree.
// One micro-rotation per cycle. Depends on imu_ca_pkg.
module imu_ca_cordic #(
    parameter int STEPS = imu_ca_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic signed [imu_ca_pkg::XY_IN_W-1:0]    i_y,
    input  logic signed [imu_ca_pkg::XY_IN_W-1:0]    i_x,
    output logic                                     o_done,
    output logic signed [imu_ca_pkg::ANG_W-1:0]      o_angle
);
    import imu_ca_pkg::*;

    localparam int XY_W = XY_IN_W + 3;
    localparam int Z_W  = 26;
    localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(STEPS - 1);
    localparam logic signed [Z_W-1:0] Z_90 = Z_W'(DEG90_Q16);
    localparam logic signed [Z_W-1:0] Z_HI = Z_W'(ANGLE_LIMIT);
    localparam logic signed [Z_W-1:0] Z_LO = -Z_W'(ANGLE_LIMIT);

    logic signed [XY_W-1:0] r_x, r_y, xe, ye, dx, dy;
    logic signed [Z_W-1:0]  r_z, atan_v, z_half;
    logic [ATAN_IDX_W-1:0]  r_cnt;
    logic                   r_run, r_fin, r_done, r_zero;
    logic signed [ANG_W-1:0] r_angle;

    assign xe = XY_W'(i_x);
    assign ye = XY_W'(i_y);
    assign dx = r_y >>> r_cnt;
    assign dy = r_x >>> r_cnt;
    assign atan_v = Z_W'(atan_q16(r_cnt));
    assign z_half = (r_z + Z_W'(1)) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin && !i_start && !r_run;
            if (i_start) begin
                r_run  <= 1'b1;
                r_cnt  <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                if (i_x < 0) begin
                    // pre-rotate into the right half plane
                    if (i_y >= 0) begin
                        r_x <= ye;
                        r_y <= -xe;
                        r_z <= Z_90;
                    end else begin
                        r_x <= -ye;
                        r_y <= xe;
                        r_z <= -Z_90;
                    end
                end else begin
                    r_x <= xe;
                    r_y <= ye;
                    r_z <= '0;
                end
            end else if (r_run) begin
                if (r_y < 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_v;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                if (r_zero) begin
                    r_angle <= '0;
                end else if (z_half > Z_HI) begin
                    r_angle <= ANG_W'(Z_HI);
                end else if (z_half < Z_LO) begin
                    r_angle <= ANG_W'(Z_LO);
                end else begin
                    r_angle <= ANG_W'(z_half);
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

### design/imu_ca_isqrt.sv
// imu_ca_isqrt: iterative integer square root, one result bit per cycle.
// Depends on imu_ca_pkg.
module imu_ca_isqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [imu_ca_pkg::SQ_IN_W-1:0]     i_val,
    output logic                               o_done,
    output logic [imu_ca_pkg::SQ_OUT_W-1:0]    o_root
);
    import imu_ca_pkg::*;

    localparam int REM_W = SQ_OUT_W + 1;
    localparam logic [4:0] LAST = 5'(SQ_OUT_W - 1);

    logic [SQ_IN_W-1:0]  r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [SQ_OUT_W-1:0] r_root;
    logic [4:0]          r_cnt;
    logic                r_run, r_done, ge;
    logic [REM_W+1:0]    rem_sh, trial;

    assign rem_sh = {r_rem, r_rad[SQ_IN_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && !i_start && (r_cnt == LAST);
            if (i_start) begin
                r_run  <= 1'b1;
                r_rad  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end else if (r_run) begin
                r_rad  <= {r_rad[SQ_IN_W-3:0], 2'b00};
                r_rem  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                r_root <= {r_root[SQ_OUT_W-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_run  <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### design/imu_ca_div.sv
// imu_ca_div: division by a constant, floor quotient of a signed numerator, from a
// reciprocal estimate and a few compare-and-subtract steps. Depends on imu_ca_pkg.
module imu_ca_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [imu_ca_pkg::DIV_N_W-1:0] i_num,
    input  logic [imu_ca_pkg::DIV_D_W-1:0]        i_den,
    input  logic [imu_ca_pkg::RECIP_W-1:0]        i_recip,
    output logic                                  o_done,
    output logic signed [imu_ca_pkg::DIV_Q_W-1:0] o_quot
);
    import imu_ca_pkg::*;

    localparam int MA_W = DIV_N_W - RECIP_SH;
    localparam int MB_W = DIV_D_W;
    localparam int MP_W = MA_W + MB_W;

    logic [DIV_N_W-1:0]         r_num, r_rem;
    logic [DIV_D_W-1:0]         r_den;
    logic [RECIP_W-1:0]         r_recip;
    logic [DIV_Q_W-1:0]         r_q;
    logic                       r_neg, r_est, r_mul, r_fix, r_done;
    logic signed [DIV_Q_W-1:0]  r_quot, q_mag;
    logic [MA_W-1:0]            mul_a;
    logic [MB_W-1:0]            mul_b;
    logic [MP_W-1:0]            prod;
    logic                       fix_ge;

    // one multiplier: estimate t*R first, then q0*d
    assign mul_a  = r_est ? r_num[DIV_N_W-1:RECIP_SH] : MA_W'(r_q);
    assign mul_b  = r_est ? MB_W'(r_recip) : r_den;
    assign prod   = MP_W'(mul_a) * MP_W'(mul_b);
    assign fix_ge = r_rem >= DIV_N_W'(r_den);
    assign q_mag  = $signed(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est  <= 1'b0;
            r_mul  <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fix && !fix_ge && !i_start;
            if (i_start) begin
                r_est   <= 1'b1;
                r_mul   <= 1'b0;
                r_fix   <= 1'b0;
                r_neg   <= i_num < 0;
                r_num   <= (i_num < 0) ? DIV_N_W'(-i_num) : DIV_N_W'(i_num);
                r_den   <= i_den;
                r_recip <= i_recip;
            end else if (r_est) begin
                // estimate never exceeds the quotient and is at most three low
                r_q   <= DIV_Q_W'(prod >> RECIP_SH);
                r_est <= 1'b0;
                r_mul <= 1'b1;
            end else if (r_mul) begin
                r_rem <= r_num - DIV_N_W'(prod);
                r_mul <= 1'b0;
                r_fix <= 1'b1;
            end else if (r_fix) begin
                if (fix_ge) begin
                    r_rem <= r_rem - DIV_N_W'(r_den);
                    r_q   <= r_q + 1'b1;
                end else begin
                    r_fix <= 1'b0;
                    // floor for negative numerators
                    if (r_neg) begin
                        r_quot <= (r_rem != '0) ? -(q_mag + DIV_Q_W'(1)) : -q_mag;
                    end else begin
                        r_quot <= q_mag;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/imu_complementary_attitude_top.sv
// imu_complementary_attitude_top: sequencer and shared multiplier for the
// complementary attitude filter. Uses imu_ca_pkg, imu_ca_cordic, imu_ca_isqrt, imu_ca_div.
//
//   channel   signals                         direction  moves
//   input     i_valid, o_stall, i_in          in         one IMU sample request
//   output    o_valid, i_stall, o_out         out        one attitude result
//   config    i_cfg_we, i_cfg_idx, i_cfg_data in         register write, no wait
//
// A seeded sample runs from acceptance back to idle through the gravity steps, a square
// root, two CORDIC passes, three gyro-step and up to two normalize divisions, and the
// blend multiply steps.
// o_stall is high from acceptance until the result is loaded into the output
// register; the next sample may then be taken while that result waits, but a finished
// result stays in the last state until the output register is free.
// Reset is synchronous, active low, clears filter state and sets configuration to its reset values.
module imu_complementary_attitude_top #(
    parameter int CORDIC_STEPS = imu_ca_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  imu_ca_pkg::t_imu_in                  i_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output imu_ca_pkg::t_imu_out                 o_out,
    input  logic                                 i_cfg_we,
    input  logic [imu_ca_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                          i_cfg_data
);
    import imu_ca_pkg::*;

    localparam logic signed [PROD_W-1:0] B_HI = PROD_W'(ANGLE_LIMIT);
    localparam logic signed [PROD_W-1:0] B_LO = -PROD_W'(ANGLE_LIMIT);
    localparam logic signed [32:0] YAW_HI = 33'sd2147483647;
    localparam logic signed [32:0] YAW_LO = -33'sd2147483648;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    t_state r_state, n_state;

    logic [15:0]        r_blend_gain, r_grav_gain;
    logic signed [15:0] r_bias_x, r_bias_y, r_bias_z;

    logic signed [15:0]       r_accel [3];
    logic signed [16:0]       r_rate_p, r_rate_r, r_rate_y;
    logic [15:0]              r_dt;
    logic signed [31:0]       r_grav [3];
    logic [1:0]               r_i, r_sel;
    logic signed [PROD_W-1:0] r_prod, r_acc;
    logic [SQ_OUT_W-1:0]      r_sqrt;
    logic signed [ANG_W-1:0]  r_ap, r_ar, r_pitch, r_roll;
    logic signed [DIV_Q_W-1:0] r_stp;
    logic signed [31:0]       r_yaw;
    logic                     r_seeded;
    logic [15:0]              r_norm_p, r_norm_r;
    logic                     r_out_valid;
    t_imu_out                 r_out;

    logic                     in_acc, load_out;
    logic signed [33:0]       mul_a;
    logic signed [24:0]       mul_b;
    logic signed [ANG_W-1:0]  v0, v1, v2, sel_angle, sel_acc_ang;
    logic signed [16:0]       sel_rate;
    logic signed [24:0]       norm_s, p_round, r_round;
    logic signed [PROD_W-1:0] blend_v, blend_sh;
    logic signed [ANG_W-1:0]  blend_res;
    logic signed [32:0]       yaw_sum;
    logic signed [31:0]       yaw_sat;
    logic [15:0]              norm_res;

    logic                        cordic_start, cordic_done;
    logic signed [XY_IN_W-1:0]   cordic_y, cordic_x;
    logic signed [ANG_W-1:0]     cordic_angle;
    logic                        sqrt_start, sqrt_done;
    logic [SQ_IN_W-1:0]          sqrt_in;
    logic [SQ_OUT_W-1:0]         sqrt_root;
    logic                        div_start, div_done;
    logic signed [DIV_N_W-1:0]   div_num;
    logic [DIV_D_W-1:0]          div_den;
    logic [RECIP_W-1:0]          div_recip;
    logic signed [DIV_Q_W-1:0]   div_quot;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    // trig operands: gravity floor-shifted right by 8
    assign v0 = r_grav[0][31:8];
    assign v1 = r_grav[1][31:8];
    assign v2 = r_grav[2][31:8];

    assign sel_angle   = (r_sel == SEL_ROLL) ? r_roll : r_pitch;
    assign sel_acc_ang = (r_sel == SEL_ROLL) ? r_ar : r_ap;

    always_comb begin
        case (r_sel)
            SEL_PITCH: sel_rate = r_rate_p;
            SEL_ROLL:  sel_rate = r_rate_r;
            default:   sel_rate = r_rate_y;
        endcase
    end

    assign norm_s    = 25'(sel_angle) + 25'(DEG45_Q15);
    assign blend_v   = r_acc + r_prod + PROD_W'(32768);
    assign blend_sh  = blend_v >>> 16;
    assign blend_res = (blend_sh > B_HI) ? ANG_W'(B_HI) :
                       (blend_sh < B_LO) ? ANG_W'(B_LO) : ANG_W'(blend_sh);
    assign yaw_sum   = 33'(r_yaw) + 33'(r_stp);
    assign yaw_sat   = (yaw_sum > YAW_HI) ? 32'(YAW_HI) :
                       (yaw_sum < YAW_LO) ? 32'(YAW_LO) : yaw_sum[31:0];
    assign norm_res  = (div_quot > 24'sd65535) ? 16'hFFFF : div_quot[15:0];
    assign p_round   = 25'(r_pitch) + 25'sd128;
    assign r_round   = 25'(r_roll) + 25'sd128;

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_GRAV0: begin
                mul_a = 34'(r_grav[r_i]);
                mul_b = {9'd0, r_grav_gain};
            end
            ST_GRAV1: begin
                mul_a = 34'(r_accel[r_i]);
                mul_b = {8'd0, 17'(GAIN_ONE - 32'(r_grav_gain))};
            end
            ST_SQ0: begin
                mul_a = 34'(v1);
                mul_b = 25'(v1);
            end
            ST_SQ1: begin
                mul_a = 34'(v2);
                mul_b = 25'(v2);
            end
            ST_STEP0: begin
                mul_a = 34'(sel_rate);
                mul_b = {9'd0, r_dt};
            end
            ST_BLEND0: begin
                mul_a = 34'(25'(sel_angle) + 25'(r_stp));
                mul_b = {9'd0, r_blend_gain};
            end
            ST_BLEND1: begin
                mul_a = 34'(sel_acc_ang);
                mul_b = {8'd0, 17'(GAIN_ONE - 32'(r_blend_gain))};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqrt_in  = SQ_IN_W'(r_acc + r_prod);
    assign cordic_y = (r_sel == SEL_PITCH) ? XY_IN_W'(v0) : XY_IN_W'(v1);
    assign cordic_x = (r_sel == SEL_PITCH) ? XY_IN_W'({1'b0, r_sqrt}) : XY_IN_W'(v2);

    always_comb begin
        if (r_state == ST_NORM) begin
            div_num   = (DIV_N_W'(norm_s) <<< 16) + DIV_N_W'(DEG45_Q15);
            div_den   = DIV_D_W'(DEG90_Q15);
            div_recip = RECIP_NORM;
        end else begin
            // gyro step: pitch/roll scale 512, yaw scale 2
            div_num = ((r_sel == SEL_YAW) ? (DIV_N_W'(r_prod) <<< 1)
                                          : (DIV_N_W'(r_prod) <<< 9))
                      + DIV_N_W'(US_ROUND);
            div_den   = DIV_D_W'(US_PER_S);
            div_recip = RECIP_US;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        cordic_start = 1'b0;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_GRAV0;
            end
            ST_GRAV0: begin
                if (r_seeded) begin
                    n_state = ST_GRAV1;
                end else if (r_i == AXIS_LAST) begin
                    n_state = ST_SQ0;
                end
            end
            ST_GRAV1: n_state = ST_GRAV2;
            ST_GRAV2: n_state = (r_i == AXIS_LAST) ? ST_SQ0 : ST_GRAV0;
            ST_SQ0:   n_state = ST_SQ1;
            ST_SQ1:   n_state = ST_SQ2;
            ST_SQ2: begin
                sqrt_start = 1'b1;
                n_state    = ST_SQW;
            end
            ST_SQW: begin
                if (sqrt_done) n_state = ST_ATAN;
            end
            ST_ATAN: begin
                cordic_start = 1'b1;
                n_state      = ST_ATANW;
            end
            ST_ATANW: begin
                if (cordic_done) n_state = (r_sel == SEL_PITCH) ? ST_ATAN : ST_STEP0;
            end
            ST_STEP0: n_state = ST_STEP1;
            ST_STEP1: begin
                div_start = 1'b1;
                n_state   = ST_STEPW;
            end
            ST_STEPW: begin
                if (div_done) n_state = (r_sel == SEL_YAW) ? ST_YAW : ST_BLEND0;
            end
            ST_BLEND0: n_state = ST_BLEND1;
            ST_BLEND1: n_state = ST_BLEND2;
            ST_BLEND2: n_state = ST_STEP0;
            ST_YAW:    n_state = ST_NORM;
            ST_NORM: begin
                if (norm_s <= 0) begin
                    n_state = (r_sel == SEL_PITCH) ? ST_NORM : ST_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_NORMW;
                end
            end
            ST_NORMW: begin
                if (div_done) n_state = (r_sel == SEL_PITCH) ? ST_NORM : ST_DONE;
            end
            ST_DONE: begin
                if (load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_gain <= BLEND_GAIN_RST;
            r_grav_gain  <= GRAVITY_GAIN_RST;
            r_bias_x     <= '0;
            r_bias_y     <= '0;
            r_bias_z     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLEND_GAIN:   r_blend_gain <= i_cfg_data;
                CFG_GRAVITY_GAIN: r_grav_gain  <= i_cfg_data;
                CFG_BIAS_X:       r_bias_x     <= i_cfg_data;
                CFG_BIAS_Y:       r_bias_y     <= i_cfg_data;
                CFG_BIAS_Z:       r_bias_z     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded    <= 1'b0;
            r_yaw       <= '0;
            r_pitch     <= '0;
            r_roll      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_accel[0] <= i_in.accel_x;
                        r_accel[1] <= i_in.accel_y;
                        r_accel[2] <= i_in.accel_z;
                        r_rate_p   <= 17'(i_in.rate_y) - 17'(r_bias_y);
                        r_rate_r   <= 17'(i_in.rate_x) - 17'(r_bias_x);
                        r_rate_y   <= 17'(i_in.rate_z) - 17'(r_bias_z);
                        r_dt       <= i_in.elapsed_us;
                        r_i        <= '0;
                        r_sel      <= SEL_PITCH;
                    end
                end
                ST_GRAV0: begin
                    if (!r_seeded) begin
                        r_grav[r_i] <= {r_accel[r_i], 16'h0000};
                        r_i         <= r_i + 1'b1;
                    end
                end
                // (k*g + 2^15) >> 16, then add (1-k)*a exactly
                ST_GRAV1: r_acc <= (r_prod + PROD_W'(32768)) >>> 16;
                ST_GRAV2: begin
                    r_grav[r_i] <= 32'(r_acc + r_prod);
                    r_i         <= r_i + 1'b1;
                end
                ST_SQ1: r_acc <= r_prod;
                ST_SQW: begin
                    if (sqrt_done) r_sqrt <= sqrt_root;
                end
                ST_ATANW: begin
                    if (cordic_done) begin
                        if (r_sel == SEL_PITCH) begin
                            r_ap  <= cordic_angle;
                            r_sel <= SEL_ROLL;
                        end else begin
                            r_ar <= cordic_angle;
                            if (r_seeded) begin
                                r_sel <= SEL_PITCH;
                            end else begin
                                // first sample: take accel angles as they are
                                r_pitch  <= r_ap;
                                r_roll   <= cordic_angle;
                                r_seeded <= 1'b1;
                                r_sel    <= SEL_YAW;
                            end
                        end
                    end
                end
                ST_STEPW: begin
                    if (div_done) r_stp <= div_quot;
                end
                ST_BLEND1: r_acc <= r_prod;
                ST_BLEND2: begin
                    if (r_sel == SEL_PITCH) begin
                        r_pitch <= blend_res;
                        r_sel   <= SEL_ROLL;
                    end else begin
                        r_roll <= blend_res;
                        r_sel  <= SEL_YAW;
                    end
                end
                ST_YAW: begin
                    r_yaw <= yaw_sat;
                    r_sel <= SEL_PITCH;
                end
                ST_NORM: begin
                    if (norm_s <= 0) begin
                        if (r_sel == SEL_PITCH) begin
                            r_norm_p <= '0;
                            r_sel    <= SEL_ROLL;
                        end else begin
                            r_norm_r <= '0;
                        end
                    end
                end
                ST_NORMW: begin
                    if (div_done) begin
                        if (r_sel == SEL_PITCH) begin
                            r_norm_p <= norm_res;
                            r_sel    <= SEL_ROLL;
                        end else begin
                            r_norm_r <= norm_res;
                        end
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_out.pitch_out  <= p_round[23:8];
                        r_out.roll_out   <= r_round[23:8];
                        r_out.yaw_out    <= r_yaw;
                        r_out.norm_pitch <= r_norm_p;
                        r_out.norm_roll  <= r_norm_r;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    imu_ca_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_y     (cordic_y),
        .i_x     (cordic_x),
        .o_done  (cordic_done),
        .o_angle (cordic_angle)
    );

    imu_ca_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (sqrt_in),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    imu_ca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_recip (div_recip),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("sample accepted but block not busy");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_valid)
        else $error("finished result not presented");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_STEPW || r_state == ST_NORMW))
        else $error("divider finished outside a wait state");

    a_pitch_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch <= ANG_W'(ANGLE_LIMIT)) && (r_pitch >= -ANG_W'(ANGLE_LIMIT)))
        else $error("pitch state beyond 180 degrees");
`endif

endmodule
